// File: sv/lkp_pkg.sv
// Shared constants and types for the last-k product engine.
`timescale 1ns / 1ps

package lkp_pkg;

    // Number of entries in each ring store.
    localparam int DEPTH  = 1024;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int K_W    = 11;
    // Width that holds both a pointer and k, plus a sign bit for wrap handling.
    localparam int SUM_W  = ((PTR_W > K_W) ? PTR_W : K_W) + 1;

    // Request kinds carried in tuser.
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: sv/last_k_product_engine.sv
// Top level of the last-k product engine: sequencer, ring stores and shared multiplier.
`timescale 1ns / 1ps

// Each request either appends a signed 32-bit number (tuser low) or asks for the
// product of the last k appended numbers (tuser high). On an append, the number
// and the running prefix product are written into two ring stores of 1024
// entries, and a zero restarts the run. A query with k of zero answers 1, and
// one with k beyond the nonzero numbers since the last zero answers 0; both go
// straight to the output stage. Any other query reads the newest prefix, then
// the prefix k places back, divides them on an iterative divider that produces one
// quotient bit per cycle, and multiplies the quotient by the number stored k places
// back. The block takes no new request while a query is in progress, but a
// finished result waits in the output register, so the next request is taken
// even while the consumer stalls, until another answer needs that register.
// All products wrap modulo 2^32.
module last_k_product_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // num [31:0], k [42:32], zero padding [47:43]
    input  logic        s_tuser,   // func: 0 append, 1 query
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // product [31:0]
);

    localparam int W     = lkp_pkg::DATA_W;
    localparam int PTR_W = lkp_pkg::PTR_W;
    localparam int CNT_W = lkp_pkg::CNT_W;
    localparam int SUM_W = lkp_pkg::SUM_W;
    localparam int K_W   = lkp_pkg::K_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD1  = 3'd1;
    localparam logic [2:0] ST_RD2  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    // Control state.
    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [W-1:0]     rp_reg, rp_next;
    logic             m_valid_reg, m_valid_next;

    // Payload registers.
    logic [W-1:0]     m_data_reg, m_data_next;
    logic [W-1:0]     res_reg, res_next;
    logic [W-1:0]     dividend_reg, dividend_next;
    logic [W-1:0]     val_reg, val_next;
    logic [W-1:0]     quot_reg, quot_next;
    logic [PTR_W-1:0] back_reg, back_next;

    // Request fields.
    logic             in_func;
    logic [W-1:0]     in_num;
    logic [K_W-1:0]   in_k;
    logic             accept;

    // Address arithmetic.
    logic [SUM_W-1:0] back_diff;
    logic [SUM_W-1:0] back_wrap;
    logic [PTR_W-1:0] back_addr;
    logic [PTR_W-1:0] newest_addr;
    logic             k_too_long;

    // Shared multiplier.
    logic [W-1:0]     mul_a, mul_b, prod;

    // Store ports.
    logic             store_we;
    logic [W-1:0]     prefix_wdata;
    logic [PTR_W-1:0] prefix_raddr;
    logic [W-1:0]     prefix_rdata;
    logic [W-1:0]     value_rdata;

    // Divider.
    logic                 div_start;
    logic [W-1:0]         div_quotient;
    lkp_pkg::div_status_t div_st;

    assign in_func = s_tuser;
    assign in_num  = s_tdata[31:0];
    assign in_k    = s_tdata[42:32];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // The entry k places back, wrapped into the ring; meaningful only when k is
    // at most the run length, which never exceeds the depth.
    assign back_diff  = SUM_W'(wp_reg) - SUM_W'(in_k);
    assign back_wrap  = back_diff[SUM_W-1] ? (back_diff + SUM_W'(lkp_pkg::DEPTH)) : back_diff;
    assign back_addr  = back_wrap[PTR_W-1:0];
    assign newest_addr = (wp_reg == '0) ? PTR_W'(lkp_pkg::DEPTH - 1) : (wp_reg - PTR_W'(1));
    assign k_too_long = (SUM_W'(in_k) > SUM_W'(run_reg));

    // While idle the multiplier extends the running product; in a query it scales
    // the quotient by the stored number.
    assign mul_a = (state_reg == ST_IDLE) ? rp_reg : quot_reg;
    assign mul_b = (state_reg == ST_IDLE) ? in_num : val_reg;
    assign prod  = mul_a * mul_b;

    assign store_we     = accept && (in_func == lkp_pkg::FUNC_APPEND);
    assign prefix_wdata = (in_num == '0) ? '0 : prod;
    assign prefix_raddr = (state_reg == ST_IDLE) ? newest_addr : back_reg;
    assign div_start    = (state_reg == ST_RD2);

    lkp_ram #(
        .WIDTH(W),
        .DEPTH(lkp_pkg::DEPTH)
    ) u_value_store (
        .aclk (aclk),
        .we   (store_we),
        .waddr(wp_reg),
        .wdata(in_num),
        .raddr(back_addr),
        .rdata(value_rdata)
    );

    lkp_ram #(
        .WIDTH(W),
        .DEPTH(lkp_pkg::DEPTH)
    ) u_prefix_store (
        .aclk (aclk),
        .we   (store_we),
        .waddr(wp_reg),
        .wdata(prefix_wdata),
        .raddr(prefix_raddr),
        .rdata(prefix_rdata)
    );

    lkp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(dividend_reg),
        .divisor (prefix_rdata),
        .quotient(div_quotient),
        .status  (div_st)
    );

    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        run_next      = run_reg;
        rp_next       = rp_reg;
        res_next      = res_reg;
        dividend_next = dividend_reg;
        val_next      = val_reg;
        quot_next     = quot_reg;
        back_next     = back_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_func == lkp_pkg::FUNC_APPEND) begin
                        wp_next = (wp_reg == PTR_W'(lkp_pkg::DEPTH - 1)) ? '0
                                                                       : (wp_reg + PTR_W'(1));
                        if (in_num == '0) begin
                            rp_next  = W'(1);
                            run_next = '0;
                        end else begin
                            rp_next = prod;
                            if (run_reg < CNT_W'(lkp_pkg::DEPTH)) begin
                                run_next = run_reg + CNT_W'(1);
                            end
                        end
                    end else begin
                        priority if (in_k == '0) begin
                            res_next   = W'(1);
                            state_next = ST_EMIT;
                        end else if (k_too_long) begin
                            res_next   = '0;
                            state_next = ST_EMIT;
                        end else begin
                            back_next  = back_addr;
                            state_next = ST_RD1;
                        end
                    end
                end
            end
            ST_RD1: begin
                // Newest prefix and the number k places back arrive now.
                dividend_next = prefix_rdata;
                val_next      = value_rdata;
                state_next    = ST_RD2;
            end
            ST_RD2: begin
                // The divisor prefix arrives now and goes straight into the divider.
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_st.done) begin
                    quot_next  = div_quotient;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                res_next   = prod;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            run_reg     <= '0;
            rp_reg      <= W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            run_reg     <= run_next;
            rp_reg      <= rp_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg   <= m_data_next;
        res_reg      <= res_next;
        dividend_reg <= dividend_next;
        val_reg      <= val_next;
        quot_reg     <= quot_next;
        back_reg     <= back_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    // The run length never counts past the ring depth.
    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= CNT_W'(lkp_pkg::DEPTH))
        else $error("run length exceeds ring depth");

    // An empty query goes straight to the output stage with an answer of one.
    a_empty_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_func == lkp_pkg::FUNC_QUERY) && (in_k == '0))
            |=> ((state_reg == ST_EMIT) && (res_reg == W'(1))))
        else $error("empty query did not answer one");

    // The pointers do not move while a query is in progress.
    a_ptr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> $stable(wp_reg) && $stable(run_reg))
        else $error("ring state changed during a query");

endmodule

// File: sv/lkp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lkp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/lkp_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lkp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lkp_pkg::DATA_W-1:0]  dividend,
    input  logic [lkp_pkg::DATA_W-1:0]  divisor,
    output logic [lkp_pkg::DATA_W-1:0]  quotient,
    output lkp_pkg::div_status_t        status
);

    localparam int W    = lkp_pkg::DATA_W;
    localparam int CW   = $clog2(W);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic          neg_reg, neg_next;
    logic          zero_reg, zero_next;

    logic [W:0]    rem_sh;
    logic [W+1:0]  trial;

    always_comb begin
        rem_sh     = {rem_reg, quo_reg[W-1]};
        trial      = {1'b0, rem_sh} - {2'b00, den_reg};
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    quo_next   = dividend[W-1] ? (W'(0) - dividend) : dividend;
                    den_next   = divisor[W-1] ? (W'(0) - divisor) : divisor;
                    rem_next   = '0;
                    neg_next   = dividend[W-1] ^ divisor[W-1];
                    zero_next  = (divisor == '0);
                    count_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // Restoring step: subtract when the shifted remainder covers the divisor.
                if (!trial[W+1]) begin
                    rem_next = trial[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                count_next = count_reg + CW'(1);
                if (count_reg == CW'(W - 1)) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // A zero divisor yields all ones; otherwise restore the sign of the magnitude.
    assign quotient    = zero_reg ? '1 : (neg_reg ? (W'(0) - quo_reg) : quo_reg);
    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_FIX);

endmodule
